>>> hdl/first_match_packet_rule_classifier_top_assert.svh
// Assertion macros used by the classifier top level.
`ifndef FIRST_MATCH_PACKET_RULE_CLASSIFIER_TOP_ASSERT_SVH
`define FIRST_MATCH_PACKET_RULE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define FMPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FMPC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FMPC_ASSERT(label, prop, msg)
`define FMPC_ASSERT_RST(label, prop, msg)
`endif

`endif

>>> hdl/fmpc_pkg.sv
package fmpc_pkg;

    localparam int MAX_RULES = 64;

    // Wide enough for rule_count and for every cell index.
    localparam int CMP_W = ($clog2(MAX_RULES) + 1 > 7) ? $clog2(MAX_RULES) + 1 : 7;

    localparam int HIT_IDX_W  = 6;
    localparam int CFG_DATA_W = 7;

    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    localparam logic [7:0]  PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_ANY   = 8'd143;
    localparam logic [15:0] PORT_WILD   = 16'd0;
    localparam logic [15:0] PORT_HIGH   = 16'd1023;
    localparam logic [5:0]  FULL_PREFIX = 6'd32;

    localparam logic [1:0] REASON_MATCH    = 2'd0;
    localparam logic [1:0] REASON_INACTIVE = 2'd1;
    localparam logic [1:0] REASON_NO_MATCH = 2'd2;

    localparam logic CFG_RULE_COUNT   = 1'b0;
    localparam logic CFG_TABLE_ACTIVE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [5:0]  slot;
        logic [1:0]  direction;
        logic [31:0] src_ip;
        logic [5:0]  src_prefix;
        logic [31:0] dst_ip;
        logic [5:0]  dst_prefix;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack_mask;
        logic        rule_action;
    } t_in_item;

    typedef struct packed {
        logic                 verdict;
        logic [1:0]           reason;
        logic [HIT_IDX_W-1:0] hit_idx;
    } t_out_item;

    // One stored rule; prefixes are kept as address masks.
    typedef struct packed {
        logic [1:0]  direction;
        logic [31:0] src_ip;
        logic [31:0] src_mask;
        logic [31:0] dst_ip;
        logic [31:0] dst_mask;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack_mask;
        logic        action;
    } t_rule;

    // Packet header moving down the cell chain with its running result.
    typedef struct packed {
        logic        done;
        t_out_item   res;
        logic [1:0]  direction;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack_mask;
    } t_token;

endpackage

>>> hdl/fmpc_cell.sv
module fmpc_cell
    import fmpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_wen,
    input  t_rule                i_rule,
    input  logic                 i_enable,
    input  logic [HIT_IDX_W-1:0] i_index,
    input  logic                 i_valid,
    input  t_token               i_tok,
    output logic                 o_valid,
    output t_token               o_tok
);

    t_rule  r_rule;
    logic   r_valid;
    t_token r_tok;
    t_token n_tok;

    logic w_dir_ok;
    logic w_sip_ok;
    logic w_dip_ok;
    logic w_proto_ok;
    logic w_ports_ok;
    logic w_ack_ok;
    logic w_hit;

    function automatic logic port_ok(input logic [15:0] pkt, input logic [15:0] rule);
        return (rule == PORT_WILD) || (rule == PORT_HIGH && pkt > PORT_HIGH) || (rule == pkt);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_rule <= i_rule;
        end
    end

    always_comb begin
        w_dir_ok   = |(i_tok.direction & r_rule.direction);
        w_sip_ok   = ((i_tok.src_ip ^ r_rule.src_ip) & r_rule.src_mask) == '0;
        w_dip_ok   = ((i_tok.dst_ip ^ r_rule.dst_ip) & r_rule.dst_mask) == '0;
        w_proto_ok = (r_rule.protocol == PROTO_ANY) || (r_rule.protocol == i_tok.protocol);
        w_ports_ok = port_ok(i_tok.sport, r_rule.sport)
                     && port_ok(i_tok.dport, r_rule.dport);
        w_ack_ok   = (i_tok.protocol != PROTO_TCP) || (|(i_tok.ack_mask & r_rule.ack_mask));
        w_hit      = w_dir_ok && w_sip_ok && w_dip_ok && w_proto_ok
                     && ((i_tok.protocol == PROTO_ICMP) || (w_ports_ok && w_ack_ok));
    end

    // Claim the transaction only if no earlier cell has.
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.done && i_enable && w_hit) begin
            n_tok.done        = 1'b1;
            n_tok.res.verdict = r_rule.action;
            n_tok.res.reason  = REASON_MATCH;
            n_tok.res.hit_idx = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

>>> hdl/first_match_packet_rule_classifier_top.sv
// An accepted classification passes through the 64 rule cells and then the output register
// to reach its result.
// Throughput: one classification per cycle while the output is taken; a rule write is
// accepted only once the cell chain has drained, and gives no result.
// Reset clears the configuration registers and all valid bits; the rule table holds
// whatever was written and must be written before it is used.
`include "first_match_packet_rule_classifier_top_assert.svh"

module first_match_packet_rule_classifier_top
    import fmpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_wen,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [6:0] r_rule_count;
    logic       r_table_active;
    logic       r_out_valid;
    t_out_item  r_out;

    logic             w_advance;
    logic             w_any_valid;
    logic             w_wr_acc;
    t_rule            w_rule;
    t_token           w_head;
    logic [MAX_RULES:0] w_valid;
    t_token           w_tok [MAX_RULES+1];

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [5:0] l;
        logic [5:0] host;
        l    = (len > FULL_PREFIX) ? FULL_PREFIX : len;
        host = FULL_PREFIX - l;
        return 32'hFFFF_FFFF << host;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_count   <= '0;
            r_table_active <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_RULE_COUNT:   r_rule_count   <= i_cfg_data[6:0];
                CFG_TABLE_ACTIVE: r_table_active <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_any_valid = |w_valid[MAX_RULES:1];
    assign o_in_ready  = (i_in.func == FUNC_CLASSIFY) ? w_advance : !w_any_valid;
    assign w_wr_acc    = i_in_valid && o_in_ready && (i_in.func == FUNC_WRITE);

    always_comb begin
        w_rule.direction = i_in.direction;
        w_rule.src_ip    = i_in.src_ip;
        w_rule.src_mask  = prefix_mask(i_in.src_prefix);
        w_rule.dst_ip    = i_in.dst_ip;
        w_rule.dst_mask  = prefix_mask(i_in.dst_prefix);
        w_rule.protocol  = i_in.protocol;
        w_rule.sport     = i_in.sport;
        w_rule.dport     = i_in.dport;
        w_rule.ack_mask  = i_in.ack_mask;
        w_rule.action    = i_in.rule_action;
    end

    // Chain entry: an inactive table settles the verdict before the first cell.
    always_comb begin
        w_head.done        = !r_table_active;
        w_head.res.verdict = !r_table_active;
        w_head.res.reason  = r_table_active ? REASON_NO_MATCH : REASON_INACTIVE;
        w_head.res.hit_idx = '0;
        w_head.direction   = i_in.direction;
        w_head.src_ip      = i_in.src_ip;
        w_head.dst_ip      = i_in.dst_ip;
        w_head.protocol    = i_in.protocol;
        w_head.sport       = i_in.sport;
        w_head.dport       = i_in.dport;
        w_head.ack_mask    = i_in.ack_mask;
    end

    assign w_valid[0] = i_in_valid && (i_in.func == FUNC_CLASSIFY);
    assign w_tok[0]   = w_head;

    for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
        logic w_en;
        logic w_wen;
        assign w_en  = CMP_W'(r_rule_count) > CMP_W'(g);
        assign w_wen = w_wr_acc && (int'(i_in.slot) == g);

        fmpc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_wen     (w_wen),
            .i_rule    (w_rule),
            .i_enable  (w_en),
            .i_index   (HIT_IDX_W'(g)),
            .i_valid   (w_valid[g]),
            .i_tok     (w_tok[g]),
            .o_valid   (w_valid[g+1]),
            .o_tok     (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_valid[MAX_RULES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_tok[MAX_RULES].res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `FMPC_ASSERT(a_write_on_empty_chain, w_wr_acc |-> !w_any_valid, "rule write with chain busy")
    `FMPC_ASSERT(a_stall_holds_chain,
        !w_advance |=> $stable(w_valid[MAX_RULES:1]),
        "chain moved while stalled")
    `FMPC_ASSERT(a_inactive_accepts,
        (o_out_valid && o_out.reason == REASON_INACTIVE) |-> (o_out.verdict && o_out.hit_idx == '0),
        "inactive result not accept")
    `FMPC_ASSERT(a_no_match_drops,
        (o_out_valid && o_out.reason == REASON_NO_MATCH) |-> (!o_out.verdict && o_out.hit_idx == '0),
        "no-match result not drop")
    `FMPC_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

>>> bench/first_match_packet_rule_classifier_top_tb.sv
`timescale 1ns / 100ps

module first_match_packet_rule_classifier_top_tb;
    import fmpc_pkg::*;

    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam int         DRAIN_WAIT = MAX_RULES + 8;
    localparam int         RANDOM_ITEMS = 1500;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_item = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic                  cfg_index = CFG_RULE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out;

    // rule table and settings as the classifier should see them
    t_in_item              rule_table[MAX_RULES];
    logic [CFG_DATA_W-1:0] table_count = '0;
    logic                  table_on = 1'b0;
    t_out_item             verdict_q[$];

    // stimulus side: items waiting for the driver, and the rules they will leave behind
    t_in_item              acl_item_q[$];
    t_in_item              rule_shadow[MAX_RULES];
    bit                    slot_written[MAX_RULES];

    int  in_gap = 0;
    int  out_stall = 0;
    bit  quiet_mode = 1'b0;
    bit  drv_busy;
    int  err_cnt = 0;
    int  n_checked = 0;
    int  n_writes = 0;
    int  n_classify = 0;
    int  n_settings = 0;
    int  n_random = 0;

    first_match_packet_rule_classifier_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------- classifier prediction ----------------

    function automatic logic prefix_hit(logic [31:0] pkt, logic [31:0] net, logic [5:0] len);
        int unsigned host;
        if (len == 0)
            return 1'b1;
        host = (len > FULL_PREFIX) ? 0 : 32 - int'(len);
        return (pkt >> host) == (net >> host);
    endfunction

    function automatic logic port_hit(logic [15:0] pkt, logic [15:0] rule);
        return rule == PORT_WILD || (rule == PORT_HIGH && pkt > PORT_HIGH) || rule == pkt;
    endfunction

    function automatic logic rule_hits(t_in_item r, t_in_item p);
        if ((p.direction & r.direction) == 2'b00)
            return 1'b0;
        if (!prefix_hit(p.src_ip, r.src_ip, r.src_prefix) ||
            !prefix_hit(p.dst_ip, r.dst_ip, r.dst_prefix))
            return 1'b0;
        if (r.protocol != PROTO_ANY && r.protocol != p.protocol)
            return 1'b0;
        if (p.protocol == PROTO_ICMP)
            return 1'b1;
        if (!port_hit(p.sport, r.sport) || !port_hit(p.dport, r.dport))
            return 1'b0;
        if (p.protocol == PROTO_TCP && (p.ack_mask & r.ack_mask) == 2'b00)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_out_item classify_header(t_in_item p);
        t_out_item res;
        int        depth;
        res.verdict = 1'b1;
        res.reason  = REASON_INACTIVE;
        res.hit_idx = '0;
        if (!table_on)
            return res;
        depth = (table_count > MAX_RULES) ? MAX_RULES : int'(table_count);
        for (int i = 0; i < depth; i++) begin
            if (rule_hits(rule_table[i], p)) begin
                res.verdict = rule_table[i].rule_action;
                res.reason  = REASON_MATCH;
                res.hit_idx = HIT_IDX_W'(i);
                return res;
            end
        end
        res.verdict = 1'b0;
        res.reason  = REASON_NO_MATCH;
        return res;
    endfunction

    function automatic void take_transaction(t_in_item it);
        if (it.func == FUNC_WRITE) begin
            if (it.slot < MAX_RULES)
                rule_table[it.slot] = it;
            n_writes++;
        end else begin
            verdict_q.push_back(classify_header(it));
            n_classify++;
        end
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, logic [8:0] want, logic [8:0] got);
        $display("[%0t] mismatch, %s: expected %0d, got %0d", $time, what, want, got);
        err_cnt++;
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (verdict_q.size() == 0) begin
            report_mismatch("result with no classification outstanding", 9'd0, 9'(got));
            return;
        end
        want = verdict_q.pop_front();
        n_checked++;
        if (got.verdict !== want.verdict)
            report_mismatch("verdict", 9'(want.verdict), 9'(got.verdict));
        if (got.reason !== want.reason)
            report_mismatch("reason", 9'(want.reason), 9'(got.reason));
        if (got.hit_idx !== want.hit_idx)
            report_mismatch("matched rule", 9'(want.hit_idx), 9'(got.hit_idx));
    endtask

    // mostly back to back, some short pauses, a few long ones
    function automatic int draw_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- driver and monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            drv_busy = in_valid;
            if (in_valid && o_in_ready) begin
                take_transaction(in_item);
                drv_busy = 1'b0;
                in_gap = draw_gap();
            end
            if (!drv_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (acl_item_q.size() > 0) begin
                    in_item  <= acl_item_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready)
                check_result(o_out);
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                out_stall = draw_gap();
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic void queue_item(t_in_item it);
        acl_item_q.push_back(it);
        if (it.func == FUNC_WRITE) begin
            rule_shadow[it.slot]  = it;
            slot_written[it.slot] = 1'b1;
        end
    endfunction

    function automatic t_in_item make_rule(logic [5:0] slot, logic [1:0] dir,
                                           logic [31:0] sip, logic [5:0] spre,
                                           logic [31:0] dip, logic [5:0] dpre,
                                           logic [7:0] proto, logic [15:0] sport,
                                           logic [15:0] dport, logic [1:0] ack, logic act);
        t_in_item r;
        r.func        = FUNC_WRITE;
        r.slot        = slot;
        r.direction   = dir;
        r.src_ip      = sip;
        r.src_prefix  = spre;
        r.dst_ip      = dip;
        r.dst_prefix  = dpre;
        r.protocol    = proto;
        r.sport       = sport;
        r.dport       = dport;
        r.ack_mask    = ack;
        r.rule_action = act;
        return r;
    endfunction

    // fields a classification ignores are left random
    function automatic t_in_item make_header(logic [1:0] dir, logic [31:0] sip,
                                             logic [31:0] dip, logic [7:0] proto,
                                             logic [15:0] sport, logic [15:0] dport,
                                             logic [1:0] ack);
        t_in_item h;
        h = {$urandom(), $urandom(), $urandom(), $urandom()};
        h.func      = FUNC_CLASSIFY;
        h.direction = dir;
        h.src_ip    = sip;
        h.dst_ip    = dip;
        h.protocol  = proto;
        h.sport     = sport;
        h.dport     = dport;
        h.ack_mask  = ack;
        return h;
    endfunction

    function automatic logic [5:0] pick_prefix();
        case ($urandom_range(0, 5))
            0, 1:    return 6'd0;
            2:       return 6'($urandom_range(1, 32));
            3, 4:    return 6'($urandom_range(24, 32));
            default: return 6'($urandom_range(33, 63));
        endcase
    endfunction

    function automatic logic [7:0] pick_protocol();
        case ($urandom_range(0, 6))
            0:       return PROTO_ICMP;
            1, 2:    return PROTO_TCP;
            3:       return PROTO_UDP;
            4:       return PROTO_ANY;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 4))
            0:       return PORT_WILD;
            1:       return PORT_HIGH;
            2:       return 16'($urandom_range(1, 1100));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_in_item random_rule(logic [5:0] slot);
        t_in_item r;
        r = {$urandom(), $urandom(), $urandom(), $urandom()};
        r.func       = FUNC_WRITE;
        r.slot       = slot;
        r.direction  = ($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
        r.src_prefix = pick_prefix();
        r.dst_prefix = pick_prefix();
        r.protocol   = pick_protocol();
        r.sport      = pick_port();
        r.dport      = pick_port();
        r.ack_mask   = ($urandom_range(0, 7) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
        return r;
    endfunction

    // keep the network part of the rule address, randomize the host part
    function automatic logic [31:0] graft(logic [31:0] net, logic [31:0] rand_part,
                                          logic [5:0] len);
        logic [31:0] mask;
        int unsigned keep;
        keep = (len > FULL_PREFIX) ? 32 : int'(len);
        mask = (keep == 0) ? 32'h0 : (~32'h0 << (32 - keep));
        return (net & mask) | (rand_part & ~mask);
    endfunction

    function automatic logic [15:0] port_for(logic [15:0] rule, logic [15:0] pkt);
        if (rule == PORT_WILD)
            return pkt;
        if (rule == PORT_HIGH)
            return ($urandom_range(0, 3) == 0) ? PORT_HIGH : 16'($urandom_range(1024, 65535));
        return rule;
    endfunction

    // header aimed at one rule, sometimes knocked just off it
    function automatic t_in_item header_for(t_in_item r);
        t_in_item h;
        h = {$urandom(), $urandom(), $urandom(), $urandom()};
        h.func      = FUNC_CLASSIFY;
        h.direction = r.direction | h.direction;
        h.src_ip    = graft(r.src_ip, h.src_ip, r.src_prefix);
        h.dst_ip    = graft(r.dst_ip, h.dst_ip, r.dst_prefix);
        if (r.protocol != PROTO_ANY)
            h.protocol = r.protocol;
        else if ($urandom_range(0, 3) != 0)
            h.protocol = pick_protocol();
        h.sport    = port_for(r.sport, h.sport);
        h.dport    = port_for(r.dport, h.dport);
        h.ack_mask = r.ack_mask | h.ack_mask;
        if ($urandom_range(0, 9) < 3) begin
            case ($urandom_range(0, 5))
                0:       h.direction = ~r.direction;
                1:       h.src_ip[$urandom_range(0, 31)] ^= 1'b1;
                2:       h.dst_ip[$urandom_range(0, 31)] ^= 1'b1;
                3:       h.protocol = pick_protocol();
                4:       h.sport = h.sport + 16'd1;
                default: h.ack_mask = ~r.ack_mask;
            endcase
        end
        return h;
    endfunction

    // settle at negedge so the driver's updates of this cycle are visible
    task automatic wait_drained();
        while (acl_item_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_table(int count, bit active);
        wait_drained();
        @(posedge i_clk);
        cfg_wen     <= 1'b1;
        cfg_index   <= CFG_RULE_COUNT;
        cfg_data    <= CFG_DATA_W'(count);
        table_count  = CFG_DATA_W'(count);
        @(posedge i_clk);
        cfg_index   <= CFG_TABLE_ACTIVE;
        cfg_data    <= CFG_DATA_W'(active);
        table_on     = active;
        @(posedge i_clk);
        cfg_wen     <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int       depth;
        int       count;
        int       phase_len;
        int       pick;
        bit       active;
        int       phase_no;
        t_in_item h;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // table off after reset: everything passes, whatever the header
        h = make_header(2'b00, 32'h0, 32'h0, 8'h00, 16'h0, 16'h0, 2'b00);
        queue_item(h);
        h = make_header(2'b11, '1, '1, 8'hFF, 16'hFFFF, 16'hFFFF, 2'b11);
        queue_item(h);

        queue_item(make_rule(0, 2'b01, 32'h0A00_0000, 6'd8, 32'h0, 6'd0, PROTO_TCP,
                             PORT_WILD, 16'd80, 2'b10, 1'b1));
        // prefix longer than 32 acts as an exact match
        queue_item(make_rule(1, 2'b10, 32'h0, 6'd0, 32'hC0A8_0105, 6'd40, PROTO_ANY,
                             PORT_HIGH, PORT_WILD, 2'b11, 1'b0));
        queue_item(make_rule(2, 2'b11, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_ICMP,
                             16'd5, 16'd5, 2'b00, 1'b1));
        queue_item(make_rule(3, 2'b11, '1, 6'd32, '1, 6'd63, 8'hFF,
                             16'hFFFF, 16'hFFFF, 2'b11, 1'b1));
        queue_item(make_rule(4, 2'b11, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_UDP,
                             PORT_HIGH, PORT_HIGH, 2'b00, 1'b0));
        queue_item(make_rule(5, 2'b00, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_ANY,
                             PORT_WILD, PORT_WILD, 2'b11, 1'b1));
        queue_item(make_rule(6, 2'b11, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_ANY,
                             PORT_WILD, PORT_WILD, 2'b01, 1'b1));
        queue_item(make_rule(7, 2'b01, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_ANY,
                             PORT_WILD, PORT_WILD, 2'b11, 1'b0));
        set_table(8, 1'b1);

        queue_item(make_header(2'b01, 32'h0A01_0203, 32'hC0A8_0101, PROTO_TCP,
                               16'd1234, 16'd80, 2'b10));
        queue_item(make_header(2'b01, 32'h0A01_0203, 32'hC0A8_0101, PROTO_TCP,
                               16'd1234, 16'd80, 2'b01));
        // port 1023 in a rule also takes 1023 itself
        queue_item(make_header(2'b10, 32'h0102_0304, 32'hC0A8_0105, PROTO_UDP,
                               16'd1023, 16'd53, 2'b00));
        queue_item(make_header(2'b10, 32'h0102_0304, 32'hC0A8_0105, PROTO_UDP,
                               16'd1024, 16'd53, 2'b00));
        queue_item(make_header(2'b10, 32'h0102_0304, 32'hC0A8_0105, PROTO_TCP,
                               16'd1022, 16'd53, 2'b10));
        queue_item(make_header(2'b10, 32'h0102_0304, 32'hC0A8_0104, PROTO_ICMP,
                               16'd9, 16'd9, 2'b00));
        queue_item(make_header(2'b01, 32'h0A00_0001, 32'h0, PROTO_ICMP,
                               16'hFFFF, 16'h0, 2'b00));
        queue_item(make_header(2'b11, '1, '1, 8'hFF, 16'hFFFF, 16'hFFFF, 2'b11));
        queue_item(make_header(2'b01, 32'h0B00_0000, 32'h0, PROTO_UDP,
                               16'd1023, 16'd2000, 2'b11));
        queue_item(make_header(2'b11, 32'h0, 32'h0, PROTO_TCP, 16'd1, 16'd2, 2'b00));
        queue_item(make_header(2'b00, 32'h0, 32'h0, PROTO_UDP, 16'd0, 16'd0, 2'b11));
        queue_item(make_header(2'b11, 32'h0, 32'h0, 8'd50, 16'd0, 16'd0, 2'b00));

        phase_no = 0;
        while (n_random < RANDOM_ITEMS) begin
            case (phase_no)
                0: count = 127;
                1: count = 0;
                2: count = MAX_RULES;
                default: begin
                    case ($urandom_range(0, 7))
                        0:       count = 0;
                        1:       count = 1;
                        2:       count = MAX_RULES;
                        3:       count = $urandom_range(MAX_RULES + 1, 127);
                        4, 5:    count = $urandom_range(2, 16);
                        default: count = $urandom_range(17, MAX_RULES);
                    endcase
                end
            endcase
            active     = (phase_no == 2) ? 1'b0 : ($urandom_range(0, 5) != 0);
            quiet_mode = ($urandom_range(0, 3) == 0);
            set_table(count, active);
            depth = (count > MAX_RULES) ? MAX_RULES : count;

            // no rule below the count may be read before it is written
            for (int s = 0; s < depth; s++) begin
                if (!slot_written[s]) begin
                    queue_item(random_rule(6'(s)));
                    n_random++;
                end
            end

            phase_len = $urandom_range(80, 200);
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    queue_item(random_rule(6'($urandom_range(0, MAX_RULES - 1))));
                else if (pick < 30 || depth == 0)
                    queue_item(make_header(2'($urandom()), $urandom(), $urandom(),
                                           8'($urandom()), 16'($urandom()),
                                           16'($urandom()), 2'($urandom())));
                else
                    queue_item(header_for(rule_shadow[$urandom_range(0, depth - 1)]));
                n_random++;
            end
            phase_no++;
        end

        wait_drained();
        $display("%0d transactions: %0d rule writes, %0d classifications, %0d results checked",
                 n_writes + n_classify, n_writes, n_classify, n_checked);
        $display("table settings exercised: %0d, mismatches: %0d", n_settings, err_cnt);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
